>>> src/pfb_pkg.sv
package pfb_pkg;

   // Panel geometry
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGES          = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_BYTES    = PAGES * DISPLAY_WIDTH;

   // Widths derived from the geometry
   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int COL_W   = $clog2(DISPLAY_WIDTH);
   localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int OFF_W   = $clog2(DISPLAY_WIDTH + 1);
   localparam int COORD_W = 8;
   localparam int CLIP_W  = COORD_W + 1;

   localparam logic [7:0] PAGE_CMD_BASE_RESET = 8'd176;

   // Item kinds
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_SCAN  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_SCAN
   } state_type;

   // Store address of one column byte of one page
   function automatic logic [ADDR_W-1:0] pfb_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(page) * ADDR_W'(DISPLAY_WIDTH);
      return base + ADDR_W'(col);
   endfunction

endpackage

>>> src/page_framebuffer_fill_and_scan_core.sv
// Monochrome page frame store, one bit per pixel, eight rows to a byte per column.
// kind (req_tuser) 0 clears the store, 1 ORs ones into a clipped half-open rectangle,
// 2 returns the next byte of the refresh stream: per page one command byte
// (page_command_base + page) flagged on rsp_tuser, then the page's column bytes,
// with rsp_tlast on the frame's last data byte. Everything runs through one
// 1024-byte store with one write and one registered read per cycle. A fill walks the
// covered column bytes (pages times clipped columns), read-modify-write pipelined
// one byte a cycle; an empty fill writes nothing. A command byte goes straight to the
// result register, a data byte first through the registered store read. After reset
// a clearing pass runs before the first item is taken; the config register may be
// written at any time.
module page_framebuffer_fill_and_scan_core
   import pfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: x_start[7:0], x_end[15:8], y_start[23:16], y_end[31:24]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: kind[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: out_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // rsp_tuser: is_command[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // Frame store
   logic [7:0] mem [STORE_BYTES];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        rd_data_ff;

   state_type state_ff, state_in;
   logic [7:0]        base_ff;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Fill walker
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [COL_W-1:0]  fill_xs_ff, fill_xs_in;
   logic [COL_W-1:0]  fill_xl_ff, fill_xl_in;
   logic [PAGE_W-1:0] fill_pl_ff, fill_pl_in;
   logic [COORD_W-1:0] fill_ys_ff, fill_ys_in;
   logic [CLIP_W-1:0] fill_ye_ff, fill_ye_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]        wr_mask_ff, wr_mask_in;

   // Scan position
   logic [PAGE_W-1:0] scan_page_ff, scan_page_in;
   logic [OFF_W-1:0]  scan_off_ff, scan_off_in;
   logic              scan_last_ff, scan_last_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_cmd_ff, rsp_cmd_in;
   logic        rsp_last_ff, rsp_last_in;

   logic               req_xfer;
   logic [COORD_W-1:0] x_start, x_end, y_start, y_end;
   logic [CLIP_W-1:0]  xe_clip, ye_clip;
   logic [7:0]         page_mask;
   logic               scan_wrap_page;
   logic [COL_W-1:0]   scan_col;

   assign x_start = req_tdata[7:0];
   assign x_end   = req_tdata[15:8];
   assign y_start = req_tdata[23:16];
   assign y_end   = req_tdata[31:24];

   assign req_tready = (state_ff == ST_IDLE) && !wr_pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_cmd_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Clip the rectangle's far edges to the display
   assign xe_clip = ({1'b0, x_end} > CLIP_W'(DISPLAY_WIDTH)) ? CLIP_W'(DISPLAY_WIDTH)
                                                             : {1'b0, x_end};
   assign ye_clip = ({1'b0, y_end} > CLIP_W'(DISPLAY_HEIGHT)) ? CLIP_W'(DISPLAY_HEIGHT)
                                                              : {1'b0, y_end};

   // Row mask of the current fill page
   always_comb begin
      logic [CLIP_W-1:0] row;
      for (int b = 0; b < 8; b++) begin
         row = CLIP_W'({page_ff, 3'(b)});
         page_mask[b] = (row >= {1'b0, fill_ys_ff}) && (row < fill_ye_ff);
      end
   end

   assign scan_wrap_page = (scan_off_ff == OFF_W'(DISPLAY_WIDTH));
   assign scan_col       = COL_W'(scan_off_ff - OFF_W'(1));

   // Next state, memory control and result register
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      fill_xs_in   = fill_xs_ff;
      fill_xl_in   = fill_xl_ff;
      fill_pl_in   = fill_pl_ff;
      fill_ys_in   = fill_ys_ff;
      fill_ye_in   = fill_ye_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_mask_in   = wr_mask_ff;
      scan_page_in = scan_page_ff;
      scan_off_in  = scan_off_ff;
      scan_last_in = scan_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_last_in  = rsp_last_ff;

      mem_we    = wr_pend_ff;
      mem_waddr = wr_addr_ff;
      mem_wdata = rd_data_ff | wr_mask_ff;
      mem_raddr = (state_ff == ST_FILL) ? pfb_addr(page_ff, col_ff)
                                        : pfb_addr(scan_page_ff, scan_col);

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep zeros through the store
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = 8'd0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_tuser)
                  KIND_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  KIND_FILL: begin
                     // Start the walk unless the clipped rectangle is empty
                     if (({1'b0, x_start} < xe_clip) && ({1'b0, y_start} < ye_clip)) begin
                        col_in     = COL_W'(x_start);
                        page_in    = PAGE_W'(y_start >> 3);
                        fill_xs_in = COL_W'(x_start);
                        fill_xl_in = COL_W'(xe_clip - CLIP_W'(1));
                        fill_pl_in = PAGE_W'((ye_clip - CLIP_W'(1)) >> 3);
                        fill_ys_in = y_start;
                        fill_ye_in = ye_clip;
                        state_in   = ST_FILL;
                     end
                  end
                  KIND_SCAN: begin
                     if (scan_off_ff == '0) begin
                        // Page command goes straight out
                        rsp_valid_in = 1'b1;
                        rsp_cmd_in   = 1'b1;
                        rsp_byte_in  = base_ff + 8'(scan_page_ff);
                        rsp_last_in  = 1'b0;
                        scan_off_in  = OFF_W'(1);
                     end else begin
                        // Data byte: read issued now, result next cycle
                        scan_last_in = scan_wrap_page &&
                                       (scan_page_ff == PAGE_W'(PAGES - 1));
                        state_in     = ST_SCAN;
                        if (scan_wrap_page) begin
                           scan_off_in  = '0;
                           scan_page_in = (scan_page_ff == PAGE_W'(PAGES - 1)) ? '0
                                        : scan_page_ff + PAGE_W'(1);
                        end else begin
                           scan_off_in = scan_off_ff + OFF_W'(1);
                        end
                     end
                  end
                  default: begin
                     // Unused kind: drop
                  end
               endcase
            end
         end
         ST_FILL: begin
            // Read one byte, OR its mask back in next cycle
            wr_pend_in = 1'b1;
            wr_addr_in = pfb_addr(page_ff, col_ff);
            wr_mask_in = page_mask;
            if (col_ff == fill_xl_ff) begin
               col_in = fill_xs_ff;
               if (page_ff == fill_pl_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  page_in = page_ff + PAGE_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_SCAN: begin
            rsp_valid_in = 1'b1;
            rsp_cmd_in   = 1'b0;
            rsp_byte_in  = rd_data_ff;
            rsp_last_in  = scan_last_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         base_ff      <= PAGE_CMD_BASE_RESET;
         wr_pend_ff   <= 1'b0;
         scan_page_ff <= '0;
         scan_off_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wr_pend_ff   <= wr_pend_in;
         scan_page_ff <= scan_page_in;
         scan_off_ff  <= scan_off_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      page_ff      <= page_in;
      fill_xs_ff   <= fill_xs_in;
      fill_xl_ff   <= fill_xl_in;
      fill_pl_ff   <= fill_pl_in;
      fill_ys_ff   <= fill_ys_in;
      fill_ye_ff   <= fill_ye_in;
      wr_addr_ff   <= wr_addr_in;
      wr_mask_ff   <= wr_mask_in;
      scan_last_ff <= scan_last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // No item is taken while a fill write is still outstanding
   a_no_xfer_during_wb: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !req_tready)
      else $error("item accepted with fill write pending");

   // The result register is free whenever a data read returns
   a_rsp_free_on_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("scan result would overwrite a waiting result");

   // The scan offset never passes the page span
   a_scan_off_range: assert property (@(posedge clock) disable iff (reset)
      scan_off_ff <= OFF_W'(DISPLAY_WIDTH))
      else $error("scan offset out of range");

   // A fill write only follows a fill read
   a_wb_after_fill: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(state_ff == ST_FILL))
      else $error("fill write without a fill read");

   // The clear pass never writes while a fill write is pending
   a_clear_no_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !wr_pend_ff)
      else $error("clear sweep collides with fill write");

endmodule
